// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL sequencer (ecpi_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/ecpi_pkg.sv -----
// Types, constants and tables for the extrinsic-corrected path integrator.
package ecpi_pkg;
	localparam int POS_W   = 32;
	localparam int ANG_W   = 16;
	localparam int TIME_W  = 32;
	localparam int OFS_W   = 24;
	localparam int OANG_W  = 16;
	localparam int CFG_W   = 24;
	localparam int TURN_W  = 32;
	localparam int STEPS   = 20;
	localparam int GUARD   = 4;
	localparam int ITER_W  = 5;
	localparam int IN_W    = ((POS_W > OFS_W) ? POS_W : OFS_W) + 3;
	localparam int CW      = IN_W + GUARD + 2;
	localparam logic [30:0] GAIN = 31'd1304065748;

	typedef enum logic [1:0] {
		CFG_OFFSET_X,
		CFG_OFFSET_Y,
		CFG_OFFSET_ANGLE
	} cfg_reg_t;

	typedef struct packed {
		logic [TIME_W-1:0]       sample_time;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [ANG_W-1:0] heading;
		logic                    path_start;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]       out_time;
		logic signed [POS_W-1:0] out_x;
		logic signed [POS_W-1:0] out_y;
		logic signed [ANG_W-1:0] out_heading;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_LOAD,
		ST_ITER,
		ST_GAIN,
		ST_STORE,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_ITER,
		OP_GAIN,
		OP_STORE,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [1:0]        rot;
		logic [ITER_W-1:0] iter;
		logic              gcomp;
		logic [1:0]        gphase;
	} dp_cmd_t;

	typedef struct packed {
		logic path_start;
	} dp_stat_t;

	function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
		case (i)
			5'd0:  atan_turn = 30'd536870912;
			5'd1:  atan_turn = 30'd316933406;
			5'd2:  atan_turn = 30'd167458907;
			5'd3:  atan_turn = 30'd85004756;
			5'd4:  atan_turn = 30'd42667331;
			5'd5:  atan_turn = 30'd21354465;
			5'd6:  atan_turn = 30'd10679838;
			5'd7:  atan_turn = 30'd5340245;
			5'd8:  atan_turn = 30'd2670163;
			5'd9:  atan_turn = 30'd1335087;
			5'd10: atan_turn = 30'd667544;
			5'd11: atan_turn = 30'd333772;
			5'd12: atan_turn = 30'd166886;
			5'd13: atan_turn = 30'd83443;
			5'd14: atan_turn = 30'd41722;
			5'd15: atan_turn = 30'd20861;
			5'd16: atan_turn = 30'd10430;
			5'd17: atan_turn = 30'd5215;
			5'd18: atan_turn = 30'd2608;
			5'd19: atan_turn = 30'd1304;
			default: atan_turn = 30'd0;
		endcase
	endfunction
endpackage

// ----- rtl/ecpi_ctrl.sv -----
// Sequencer for the integrator: handshakes, rotation and gain step control.
`include "assert_macros.svh"
module ecpi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ecpi_pkg::dp_stat_t stat,
	output ecpi_pkg::dp_cmd_t  cmd
);
	import ecpi_pkg::*;

	state_t            state_q, state_d;
	logic [ITER_W-1:0] iter_q, iter_d;
	logic [2:0]        gstep_q, gstep_d;
	logic [1:0]        rot_q, rot_d;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q  <= '0;
			gstep_q <= '0;
			rot_q   <= '0;
		end else begin
			iter_q  <= iter_d;
			gstep_q <= gstep_d;
			rot_q   <= rot_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		iter_d     = iter_q;
		gstep_d    = gstep_q;
		rot_d      = rot_q;
		in_stall   = 1'b1;
		cmd.op     = OP_NONE;
		cmd.rot    = rot_q;
		cmd.iter   = iter_q;
		cmd.gcomp  = (gstep_q >= 3'd3);
		cmd.gphase = (gstep_q >= 3'd3) ? 2'(gstep_q - 3'd3) : gstep_q[1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_START;
				end
			end
			ST_START: begin
				rot_d   = 2'd0;
				state_d = stat.path_start ? ST_FINISH : ST_LOAD;
			end
			ST_LOAD: begin
				cmd.op  = OP_LOAD;
				iter_d  = '0;
				state_d = ST_ITER;
			end
			ST_ITER: begin
				cmd.op = OP_ITER;
				iter_d = iter_q + 1'b1;
				if (iter_q == ITER_W'(STEPS - 1)) begin
					gstep_d = '0;
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				cmd.op  = OP_GAIN;
				gstep_d = gstep_q + 1'b1;
				if (gstep_q == 3'd5) state_d = ST_STORE;
			end
			ST_STORE: begin
				cmd.op = OP_STORE;
				if (rot_q == 2'd2) state_d = ST_FINISH;
				else begin
					rot_d   = rot_q + 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.op == OP_FINISH) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMPL(a_finish_free, cmd.op == OP_FINISH, !out_valid_q || !out_stall)
	`ASSERT_IMPL(a_iter_range, state_q == ST_ITER, iter_q < ITER_W'(STEPS))
	`ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state_q == ST_START)
	`ASSERT_NEXT(a_out_drain, out_valid_q && !out_stall && cmd.op != OP_FINISH, !out_valid_q)
endmodule

// ----- rtl/ecpi_dp.sv -----
// Datapath: pose state, shared CORDIC rotator, gain multiplier and path update.
module ecpi_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [ecpi_pkg::CFG_W-1:0] cfg_data,
	input  ecpi_pkg::in_item_t        in_data,
	input  ecpi_pkg::dp_cmd_t         cmd,
	output ecpi_pkg::dp_stat_t        stat,
	output ecpi_pkg::out_item_t       out_data
);
	import ecpi_pkg::*;

	localparam int AL = TURN_W - ANG_W;
	localparam logic signed [IN_W:0] PMAX = {{(IN_W-POS_W+2){1'b0}}, {(POS_W-1){1'b1}}};
	localparam logic signed [IN_W:0] PMIN = {{(IN_W-POS_W+2){1'b1}}, {(POS_W-1){1'b0}}};

	logic signed [OFS_W-1:0]  ofs_x_q, ofs_y_q;
	logic [OANG_W-1:0]        ofs_a_q;
	logic signed [POS_W-1:0]  last_x_q, last_y_q, path_x_q, path_y_q;
	logic [ANG_W-1:0]         last_h_q, path_h_q;
	in_item_t                 in_q;
	out_item_t                out_q;
	logic signed [CW-1:0]     cx_q, cy_q;
	logic signed [TURN_W-1:0] z_q;
	logic [CW-1:0]            mag_q;
	logic                     neg_q;
	logic [63:0]              prod_q, acc_q;
	logic signed [IN_W-1:0]   gx_q, gy_q, tx_q, ty_q, ux_q, uy_q, vx_q, vy_q;

	logic [TURN_W-1:0]      lh_turn, d_turn, a_sel, a_off, r_turn;
	logic [1:0]             quad;
	logic signed [IN_W-1:0] opx, opy;
	logic signed [CW-1:0]   lx, ly, sx, sy, gc, gmag_s;
	logic [CW-1:0]          gmag;
	logic [64:0]            rmag;
	logic signed [CW+1:0]   rs, rnd;
	logic signed [POS_W-1:0] nx, ny;
	logic [ANG_W-1:0]        nh;

	function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0] p,
			input logic signed [IN_W-1:0] v);
		logic signed [IN_W:0] s;
		s = (IN_W+1)'(p) + (IN_W+1)'(v);
		if (s > PMAX) sat_add = {1'b0, {(POS_W-1){1'b1}}};
		else if (s < PMIN) sat_add = {1'b1, {(POS_W-1){1'b0}}};
		else sat_add = s[POS_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			ofs_a_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET_X:     ofs_x_q <= cfg_data[OFS_W-1:0];
				CFG_OFFSET_Y:     ofs_y_q <= cfg_data[OFS_W-1:0];
				CFG_OFFSET_ANGLE: ofs_a_q <= cfg_data[OANG_W-1:0];
				default: ;
			endcase
		end
	end

	assign lh_turn = {last_h_q, {AL{1'b0}}};
	assign d_turn  = {in_q.heading, {AL{1'b0}}} - lh_turn;
	assign a_off   = {ofs_a_q, {(TURN_W-OANG_W){1'b0}}} - lh_turn;

	always_comb begin
		case (cmd.rot)
			2'd0: begin
				a_sel = a_off;
				opx   = IN_W'(in_q.pos_x) - IN_W'(last_x_q);
				opy   = IN_W'(in_q.pos_y) - IN_W'(last_y_q);
			end
			2'd1: begin
				a_sel = d_turn;
				opx   = IN_W'(ofs_x_q);
				opy   = IN_W'(ofs_y_q);
			end
			default: begin
				a_sel = {path_h_q, {AL{1'b0}}};
				opx   = ux_q;
				opy   = uy_q;
			end
		endcase
		quad   = 2'((a_sel + 32'h2000_0000) >> 30);
		r_turn = a_sel - {quad, 30'b0};
		lx     = CW'(opx) <<< GUARD;
		ly     = CW'(opy) <<< GUARD;
		sx     = cx_q >>> cmd.iter;
		sy     = cy_q >>> cmd.iter;
		gc     = cmd.gcomp ? cy_q : cx_q;
		gmag_s = -gc;
		gmag   = gc[CW-1] ? gmag_s : gc;
		rmag   = {prod_q, 1'b0} + 65'(acc_q >> 31);
		rs     = neg_q ? -(CW+2)'({2'b0, rmag[CW-1:0]}) : (CW+2)'({2'b0, rmag[CW-1:0]});
		rnd    = (rs + (CW+2)'(8)) >>> GUARD;
		nx     = sat_add(path_x_q, vx_q);
		ny     = sat_add(path_y_q, vy_q);
		nh     = path_h_q + (in_q.heading - last_h_q);
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: in_q <= in_data;
			OP_LOAD: begin
				z_q <= r_turn;
				case (quad)
					2'd0: begin cx_q <= lx;  cy_q <= ly;  end
					2'd1: begin cx_q <= -ly; cy_q <= lx;  end
					2'd2: begin cx_q <= -lx; cy_q <= -ly; end
					default: begin cx_q <= ly; cy_q <= -lx; end
				endcase
			end
			OP_ITER: begin
				if (!z_q[TURN_W-1]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					z_q  <= z_q - TURN_W'(atan_turn(cmd.iter));
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					z_q  <= z_q + TURN_W'(atan_turn(cmd.iter));
				end
			end
			OP_GAIN: begin
				case (cmd.gphase)
					2'd0: begin
						mag_q  <= gmag;
						neg_q  <= gc[CW-1];
						prod_q <= {32'b0, gmag[31:0]} * {33'b0, GAIN};
					end
					2'd1: begin
						acc_q  <= prod_q + 64'h4000_0000;
						prod_q <= 64'(mag_q[CW-1:32]) * {33'b0, GAIN};
					end
					default: begin
						if (cmd.gcomp) gy_q <= rnd[IN_W-1:0];
						else gx_q <= rnd[IN_W-1:0];
					end
				endcase
			end
			OP_STORE: begin
				case (cmd.rot)
					2'd0: begin tx_q <= gx_q; ty_q <= gy_q; end
					2'd1: begin
						ux_q <= tx_q + IN_W'(ofs_x_q) - gx_q;
						uy_q <= ty_q + IN_W'(ofs_y_q) - gy_q;
					end
					default: begin vx_q <= gx_q; vy_q <= gy_q; end
				endcase
			end
			OP_FINISH: begin
				out_q.out_time <= in_q.sample_time;
				if (in_q.path_start) begin
					out_q.out_x       <= '0;
					out_q.out_y       <= '0;
					out_q.out_heading <= '0;
				end else begin
					out_q.out_x       <= nx;
					out_q.out_y       <= ny;
					out_q.out_heading <= nh;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			last_h_q <= '0;
			path_x_q <= '0;
			path_y_q <= '0;
			path_h_q <= '0;
		end else if (cmd.op == OP_FINISH) begin
			last_x_q <= in_q.pos_x;
			last_y_q <= in_q.pos_y;
			last_h_q <= in_q.heading;
			if (in_q.path_start) begin
				path_x_q <= '0;
				path_y_q <= '0;
				path_h_q <= '0;
			end else begin
				path_x_q <= nx;
				path_y_q <= ny;
				path_h_q <= nh;
			end
		end
	end

	assign stat.path_start = in_q.path_start;
	assign out_data = out_q;
endmodule

// ----- rtl/extrinsic_corrected_path_integrator_core.sv -----
// Top level of the extrinsic-corrected path integrator.
// Each pose request yields one corrected path pose. A path-start pose only passes
// capture, a path-start check and result write; any other pose also runs three
// rotations one after another on one shared CORDIC unit (1 load, 20 micro-rotations,
// 6 gain steps on a shared 32x31 multiplier, 1 store each).
// The result write waits while the previous result is stalled in the output register.
// A new pose is taken while the previous result still waits in the output register.
module extrinsic_corrected_path_integrator_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  ecpi_pkg::in_item_t         in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ecpi_pkg::out_item_t        out_data,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [ecpi_pkg::CFG_W-1:0] cfg_data
);
	import ecpi_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ecpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ecpi_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);
endmodule

// ----- verif/extrinsic_corrected_path_integrator_core_test.sv -----
// Self-checking testbench for the extrinsic-corrected path integrator core.
`timescale 1ns / 100ps

module extrinsic_corrected_path_integrator_core_test;
	import ecpi_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam longint unsigned GAIN_Q31 = 64'd1304065748;
	localparam longint ATAN_STEP [20] = '{
		536870912, 316933406, 167458907, 85004756, 42667331,
		21354465, 10679838, 5340245, 2670163, 1335087,
		667544, 333772, 166886, 83443, 41722,
		20861, 10430, 5215, 2608, 1304
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	extrinsic_corrected_path_integrator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	longint      ofs_x, ofs_y, prev_x, prev_y, acc_x, acc_y;
	logic [31:0] ofs_turn, prev_turn, acc_turn;

	out_item_t   pose_queue[$];
	int          errors;
	int          idle_cycles;
	bit          gaps_on;

	// random walk state for stimulus
	logic signed [31:0] walk_x, walk_y;
	logic signed [15:0] walk_h;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint gain_scale(input longint v);
		logic neg;
		longint unsigned m, hi, lo, r;
		neg = v < 0;
		m = neg ? longint'(-v) : longint'(v);
		hi = m >> 32;
		lo = m & 64'hFFFF_FFFF;
		r = hi * GAIN_Q31 * 2 + ((lo * GAIN_Q31 + (64'd1 << 30)) >> 31);
		return neg ? -longint'(r) : longint'(r);
	endfunction

	function automatic void rotate_vec(input longint x, input longint y,
			input logic [31:0] a, output longint ox, output longint oy);
		logic [1:0]  q;
		logic [31:0] r;
		longint      z, cx, cy, t, sx, sy;
		q = 2'((a + 32'h2000_0000) >> 30);
		r = a - {q, 30'b0};
		z = longint'($signed(r));
		cx = x * 16;
		cy = y * 16;
		case (q)
			2'd1: begin t = cx; cx = -cy; cy = t; end
			2'd2: begin cx = -cx; cy = -cy; end
			2'd3: begin t = cx; cx = cy; cy = -t; end
			default: ;
		endcase
		for (int i = 0; i < 20; i++) begin
			sx = cx >>> i;
			sy = cy >>> i;
			if (z >= 0) begin
				cx -= sy; cy += sx; z -= ATAN_STEP[i];
			end else begin
				cx += sy; cy -= sx; z += ATAN_STEP[i];
			end
		end
		ox = (gain_scale(cx) + 8) >>> 4;
		oy = (gain_scale(cy) + 8) >>> 4;
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic out_item_t integrate_pose(input in_item_t it);
		longint      px, py, tx, ty, rx, ry, vx, vy;
		logic [31:0] h, d;
		out_item_t   o;
		px = longint'(it.pos_x);
		py = longint'(it.pos_y);
		h = {it.heading, 16'b0};
		if (it.path_start) begin
			acc_x = 0; acc_y = 0; acc_turn = '0;
		end else begin
			d = h - prev_turn;
			rotate_vec(px - prev_x, py - prev_y, ofs_turn - prev_turn, tx, ty);
			rotate_vec(ofs_x, ofs_y, d, rx, ry);
			rotate_vec(tx + ofs_x - rx, ty + ofs_y - ry, acc_turn, vx, vy);
			acc_x = clamp_pos(acc_x + vx);
			acc_y = clamp_pos(acc_y + vy);
			acc_turn = acc_turn + d;
		end
		prev_x = px; prev_y = py; prev_turn = h;
		o.out_time = it.sample_time;
		o.out_x = acc_x[31:0];
		o.out_y = acc_y[31:0];
		o.out_heading = acc_turn[31:16];
		return o;
	endfunction

	task automatic send_pose(input in_item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		pose_queue.insert(pose_queue.size(), integrate_pose(it));
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OFFSET_X: ofs_x = longint'($signed(val));
			CFG_OFFSET_Y: ofs_y = longint'($signed(val));
			CFG_OFFSET_ANGLE: ofs_turn = {val[15:0], 16'b0};
			default: ;
		endcase
	endtask

	task automatic set_extrinsic(input logic [23:0] x, input logic [23:0] y,
			input logic [23:0] a);
		write_reg(CFG_OFFSET_X, x);
		write_reg(CFG_OFFSET_Y, y);
		write_reg(CFG_OFFSET_ANGLE, a);
	endtask

	function automatic in_item_t pose(input logic [31:0] t, input logic [31:0] x,
			input logic [31:0] y, input logic [15:0] h, input logic s);
		in_item_t it;
		it.sample_time = t;
		it.pos_x = x;
		it.pos_y = y;
		it.heading = h;
		it.path_start = s;
		return it;
	endfunction

	// mostly a smooth random walk, sometimes jumps, new paths and wild poses
	function automatic in_item_t next_pose();
		in_item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			walk_x = $urandom; walk_y = $urandom; walk_h = 16'($urandom);
		end else if (pick < 20) begin
			walk_x += $signed($urandom_range(0, 1 << 27)) - (1 << 26);
			walk_y += $signed($urandom_range(0, 1 << 27)) - (1 << 26);
			walk_h += 16'($urandom);
		end else begin
			walk_x += $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			walk_y += $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			walk_h += 16'($signed($urandom_range(0, 4096)) - 2048);
		end
		it = pose($urandom, walk_x, walk_y, walk_h, $urandom_range(0, 30) == 0);
		return it;
	endfunction

	task automatic random_poses(input int n);
		for (int i = 0; i < n; i++) send_pose(next_pose());
	endtask

	// first poses after reset integrate from the zero pose
	task automatic test_from_reset;
		send_pose(pose(32'd0, 32'h0001_0000, 32'h0000_8000, 16'h0000, 1'b0));
		send_pose(pose(32'd1, 32'h0002_0000, 32'h0001_0000, 16'h2000, 1'b0));
		send_pose(pose(32'hFFFF_FFFF, 32'h0002_0000, 32'h0001_0000, 16'h2000, 1'b0));
	endtask

	task automatic test_path_start;
		send_pose(pose(32'd10, 32'h1234_5678, 32'hEDCB_A987, 16'h7FFF, 1'b1));
		send_pose(pose(32'd11, 32'h1235_5678, 32'hEDCB_A987, 16'h8000, 1'b0));
		send_pose(pose(32'd12, 32'h1235_5678, 32'hEDCC_A987, 16'hC000, 1'b0));
		send_pose(pose(32'd13, 32'h0, 32'h0, 16'h0, 1'b1));
	endtask

	task automatic test_saturation;
		send_pose(pose(32'd20, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b1));
		send_pose(pose(32'd21, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0));
		send_pose(pose(32'd22, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 1'b0));
		send_pose(pose(32'd23, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0));
		send_pose(pose(32'd24, 32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 1'b0));
		send_pose(pose(32'd25, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000, 1'b0));
		send_pose(pose(32'd26, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h4000, 1'b0));
	endtask

	task automatic test_heading_wrap;
		send_pose(pose(32'd30, 32'h0, 32'h0, 16'h7000, 1'b1));
		for (int i = 0; i < 8; i++)
			send_pose(pose(32'd31 + i, 32'(i) << 16, 32'h0, 16'h7000 + 16'(i * 16'h3000),
				1'b0));
	endtask

	task automatic test_extrinsic_settings;
		drain();
		set_extrinsic(24'h7F_FFFF, 24'h80_0000, 24'hFF_7FFF);
		random_poses(60);
		drain();
		set_extrinsic(24'h80_0000, 24'h7F_FFFF, 24'h00_8000);
		random_poses(60);
		drain();
		set_extrinsic(24'h01_8000, 24'hFF_C000, 24'h00_2000);
		random_poses(60);
		drain();
		set_extrinsic(24'($urandom), 24'($urandom), 24'($urandom));
		random_poses(60);
	endtask

	task automatic test_random_traffic;
		for (int blk = 0; blk < 8; blk++) begin
			random_poses(100);
			if (blk == 3) begin
				drain();
				set_extrinsic(24'($urandom_range(0, 1 << 20)) - 24'(1 << 19),
					24'($urandom_range(0, 1 << 20)) - 24'(1 << 19), 24'($urandom));
			end
		end
	endtask

	task automatic test_no_idle;
		gaps_on = 1'b0;
		random_poses(150);
	endtask

	// output stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pose_queue.size() == 0) begin
				$error("unexpected result time=%0h", out_data.out_time);
				errors++;
			end else begin
				out_item_t want;
				want = pose_queue.pop_front();
				if (out_data.out_time !== want.out_time) begin
					$error("out_time expected %0h actual %0h", want.out_time,
						out_data.out_time);
					errors++;
				end
				if (out_data.out_x !== want.out_x) begin
					$error("out_x expected %0d actual %0d", want.out_x, out_data.out_x);
					errors++;
				end
				if (out_data.out_y !== want.out_y) begin
					$error("out_y expected %0d actual %0d", want.out_y, out_data.out_y);
					errors++;
				end
				if (out_data.out_heading !== want.out_heading) begin
					$error("out_heading expected %0h actual %0h", want.out_heading,
						out_data.out_heading);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("extrinsic_corrected_path_integrator_core_test NOT OK");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_OFFSET_X;
		cfg_data = '0;
		errors = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		ofs_x = 0; ofs_y = 0; ofs_turn = '0;
		prev_x = 0; prev_y = 0; prev_turn = '0;
		acc_x = 0; acc_y = 0; acc_turn = '0;
		walk_x = '0; walk_y = '0; walk_h = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_from_reset();
		test_path_start();
		test_saturation();
		test_heading_wrap();
		test_extrinsic_settings();
		test_random_traffic();
		test_no_idle();
		drain();
		if (errors == 0)
			$display("extrinsic_corrected_path_integrator_core_test OK");
		else
			$display("extrinsic_corrected_path_integrator_core_test NOT OK");
		$finish;
	end
endmodule
